// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pde_pkg.sv -----
// Types, constants and helpers of the polynomial derivative evaluator.
package pde_pkg;

	localparam int COEF_W  = 32;
	localparam int ACC_W   = 48;
	localparam int FACT_W  = 13;
	localparam int DEG_W   = 3;
	localparam int ORDER_W = 4;
	localparam int SCALE_W = 46;
	localparam int PLO_W   = 65;
	localparam int FULL_W  = 80;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	// Register index, taken from paddr[2].
	localparam logic REG_POLY_DEGREE = 1'b0;

	localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Falling factorial j!/(j-k)!, row j, column k; zero where k > j.
	localparam logic [FACT_W-1:0] FALL_FACT [8][8] = '{
		'{13'd1, 13'd0, 13'd0,  13'd0,   13'd0,   13'd0,    13'd0,    13'd0},
		'{13'd1, 13'd1, 13'd0,  13'd0,   13'd0,   13'd0,    13'd0,    13'd0},
		'{13'd1, 13'd2, 13'd2,  13'd0,   13'd0,   13'd0,    13'd0,    13'd0},
		'{13'd1, 13'd3, 13'd6,  13'd6,   13'd0,   13'd0,    13'd0,    13'd0},
		'{13'd1, 13'd4, 13'd12, 13'd24,  13'd24,  13'd0,    13'd0,    13'd0},
		'{13'd1, 13'd5, 13'd20, 13'd60,  13'd120, 13'd120,  13'd0,    13'd0},
		'{13'd1, 13'd6, 13'd30, 13'd120, 13'd360, 13'd720,  13'd720,  13'd0},
		'{13'd1, 13'd7, 13'd42, 13'd210, 13'd840, 13'd2520, 13'd5040, 13'd5040}
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_ACC,
		ST_DONE
	} pde_state_t;

	typedef struct packed {
		logic start;
		logic wr_coef;
		logic mul;
		logic sum;
		logic acc;
		logic emit;
	} pde_cmd_t;

	typedef struct packed {
		logic order_high;
		logic last_step;
		logic out_free;
	} pde_status_t;

endpackage

// ----- sv/pde_ctrl.sv -----
// Sequencer of the evaluator: steps the multiply, shift and accumulate loop.
module pde_ctrl import pde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  pde_status_t status,
	output pde_cmd_t    cmd
);

	pde_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == MODE_EVAL) begin
						cmd.start = 1'b1;
						state_d   = status.order_high ? ST_DONE : ST_MUL;
					end else begin
						cmd.wr_coef = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.last_step ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				// hold until the output register has room
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/pde_datapath.sv -----
// Coefficient store, multipliers, accumulator and output register.
module pde_datapath import pde_pkg::*; #(
	parameter int MAX_DEGREE = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pde_cmd_t                  cmd,
	output pde_status_t               status,
	input  logic [DEG_W-1:0]          poly_degree,
	input  logic [DEG_W-1:0]          coef_index,
	input  logic signed [COEF_W-1:0]  coef_value,
	input  logic signed [COEF_W-1:0]  eval_point,
	input  logic [ORDER_W-1:0]        deriv_order,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ACC_W-1:0]   result_value,
	output logic                      overflow
);

	// Only indexes reachable by the 3-bit index and degree get storage.
	localparam int STORE_DEPTH = ((MAX_DEGREE < 7) ? MAX_DEGREE : 7) + 1;
	localparam logic [DEG_W-1:0] DEG_CAP = DEG_W'(STORE_DEPTH - 1);

	logic signed [COEF_W-1:0]  coef_q [STORE_DEPTH];
	logic signed [COEF_W-1:0]  x_q;
	logic [DEG_W-1:0]          k_q;
	logic [DEG_W-1:0]          j_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      ovf_q;
	logic signed [PLO_W-1:0]   plo_q;
	logic signed [ACC_W-1:0]   phi_q;
	logic signed [SCALE_W-1:0] sc_q;
	logic signed [ACC_W-1:0]   p_q;
	logic                      out_valid_q;
	logic signed [ACC_W-1:0]   result_q;
	logic                      overflow_q;

	logic [DEG_W-1:0]          deg_eff;
	logic signed [COEF_W-1:0]  coef_rd;
	logic [FACT_W-1:0]         factor;
	logic signed [PLO_W-1:0]   x65, lo65;
	logic signed [ACC_W-1:0]   x48, hi48;
	logic signed [SCALE_W-1:0] c46, f46;
	logic signed [FULL_W-1:0]  hi80, lo80, full80;
	logic [63:0]               shifted;
	logic                      sum_ovf;
	logic signed [ACC_W-1:0]   sum_sat;
	logic signed [ACC_W:0]     pe, se, acc_sum;
	logic                      acc_ovf;
	logic signed [ACC_W-1:0]   acc_sat;

	assign deg_eff = (poly_degree > DEG_CAP) ? DEG_CAP : poly_degree;

	always_comb begin
		coef_rd = '0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (j_q == DEG_W'(i)) begin
				coef_rd = coef_q[i];
			end
		end
	end

	assign factor = FALL_FACT[j_q][k_q];

	// partial products of acc * x: low 32 bits unsigned, high 16 bits signed
	assign x65  = {{(PLO_W-COEF_W){x_q[COEF_W-1]}}, x_q};
	assign lo65 = {33'b0, acc_q[31:0]};
	assign x48  = {{(ACC_W-COEF_W){x_q[COEF_W-1]}}, x_q};
	assign hi48 = {{32{acc_q[ACC_W-1]}}, acc_q[ACC_W-1:32]};
	assign c46  = {{(SCALE_W-COEF_W){coef_rd[COEF_W-1]}}, coef_rd};
	assign f46  = {{(SCALE_W-FACT_W){1'b0}}, factor};

	// recombine, floor-shift by 16 and saturate
	assign hi80    = {phi_q, 32'b0};
	assign lo80    = {{(FULL_W-PLO_W){plo_q[PLO_W-1]}}, plo_q};
	assign full80  = hi80 + lo80;
	assign shifted = full80[FULL_W-1:16];
	assign sum_ovf = !((&shifted[63:ACC_W-1]) || !(|shifted[63:ACC_W-1]));
	assign sum_sat = sum_ovf ? (shifted[63] ? SAT_MIN : SAT_MAX) : shifted[ACC_W-1:0];

	assign pe      = {p_q[ACC_W-1], p_q};
	assign se      = {{(ACC_W+1-SCALE_W){sc_q[SCALE_W-1]}}, sc_q};
	assign acc_sum = pe + se;
	assign acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
	assign acc_sat = acc_ovf ? (acc_sum[ACC_W] ? SAT_MIN : SAT_MAX) : acc_sum[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				coef_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_coef) begin
				for (int i = 0; i < STORE_DEPTH; i++) begin
					if (coef_index == DEG_W'(i)) begin
						coef_q[i] <= coef_value;
					end
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= eval_point;
			k_q   <= deriv_order[DEG_W-1:0];
			j_q   <= deg_eff;
			acc_q <= '0;
			ovf_q <= 1'b0;
		end
		if (cmd.mul) begin
			plo_q <= x65 * lo65;
			phi_q <= x48 * hi48;
			sc_q  <= c46 * f46;
		end
		if (cmd.sum) begin
			p_q   <= sum_sat;
			ovf_q <= ovf_q | sum_ovf;
		end
		if (cmd.acc) begin
			acc_q <= acc_sat;
			ovf_q <= ovf_q | acc_ovf;
			if (j_q != k_q) begin
				j_q <= j_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			result_q   <= acc_q;
			overflow_q <= ovf_q;
		end
	end

	assign status.order_high = deriv_order > {1'b0, deg_eff};
	assign status.last_step  = j_q == k_q;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign overflow     = overflow_q;

endmodule

// ----- sv/polynomial_derivative_evaluator.sv -----
// Top level of the polynomial derivative evaluator: register port and units.
//
// Input channel (in_valid / in_ready) carries one word per item. mode selects
// a coefficient write (coef_index, coef_value) or an evaluation (eval_point,
// deriv_order). A write yields no result; an evaluation yields exactly one
// word on the output channel (out_valid / out_ready): result_value in signed
// Q31.16 and a sticky overflow flag for any saturation along the way.
// The degree in use comes from register poly_degree at byte address 0 of the
// APB-style port; write it only while the block is idle.
// A write leaves the input ready. An evaluation of order k on degree d
// runs the Horner loop d-k+1 times, each pass stepping through partial
// products, recombine with shift and saturate, and scaled coefficient add;
// when k exceeds d the loop is skipped. The input stays busy until the
// result word is handed to the output register.
// Reset clears the coefficients and poly_degree to zero and empties the
// output register. The output register parts the two sides: a finished word
// waits there while the next item is taken; an evaluation that finishes
// while the receiver still stalls holds in its last state until room frees.
module polynomial_derivative_evaluator import pde_pkg::*; #(
	parameter int MAX_DEGREE = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [DEG_W-1:0]          coef_index,
	input  logic signed [COEF_W-1:0]  coef_value,
	input  logic signed [COEF_W-1:0]  eval_point,
	input  logic [ORDER_W-1:0]        deriv_order,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ACC_W-1:0]   result_value,
	output logic                      overflow
);

	logic [DEG_W-1:0] poly_degree_q;
	pde_cmd_t         cmd;
	pde_status_t      status;

	// Register write lands on the access cycle; paddr[1:0] is not decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_degree_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_POLY_DEGREE)) begin
			poly_degree_q <= pwdata[DEG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POLY_DEGREE) ? {{(32-DEG_W){1'b0}}, poly_degree_q} : '0;

	pde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.status   (status),
		.cmd      (cmd)
	);

	pde_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.poly_degree  (poly_degree_q),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.eval_point   (eval_point),
		.deriv_order  (deriv_order),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.overflow     (overflow)
	);

endmodule

// ----- sv/pde_checker.sv -----
// Port-level checks of the evaluator, bound to the top level.
`include "assert_macros.svh"

module pde_checker import pde_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     mode,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [ACC_W-1:0]  result_value,
	input logic                     overflow
);

	// a stalled result word holds
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(overflow), "result word changed while stalled")
	// an evaluation leaves the block busy
	`ASSERT_CLK(a_eval_busy, in_valid && in_ready && (mode == MODE_EVAL) |=> !in_ready, "input ready right after an evaluation")
	// a coefficient write leaves the block ready
	`ASSERT_CLK(a_write_ready, in_valid && in_ready && (mode == MODE_WRITE) |=> in_ready, "input not ready after a coefficient write")
	// no result word under reset
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result word shown during reset")

endmodule

bind polynomial_derivative_evaluator pde_checker u_pde_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.mode         (mode),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_value (result_value),
	.overflow     (overflow)
);
